FILE: sv/tpww_pkg.sv
// ----------------------------------------------------------------------------
// tpww_pkg: shared types and constants of the page word-wrap engine
// Payload structs, opcode and register index codes, UTF-8 fold constants.
// ----------------------------------------------------------------------------
package tpww_pkg;

    // input opcodes
    localparam logic [1:0] OP_TEXT     = 2'd0;
    localparam logic [1:0] OP_EOT      = 2'd1;
    localparam logic [1:0] OP_NEW_PAGE = 2'd2;

    // result kinds
    localparam logic KIND_GLYPH = 1'b0;
    localparam logic KIND_BREAK = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM     = 3'd4;

    // configuration reset values
    localparam logic [31:0] RST_PAGE_START = 32'd0;
    localparam logic [6:0]  RST_LEFT       = 7'd2;
    localparam logic [6:0]  RST_RIGHT      = 7'd125;
    localparam logic [5:0]  RST_TOP        = 6'd2;
    localparam logic [5:0]  RST_BOTTOM     = 6'd61;

    // decoder states: idle, after E2 80, otherwise the pending lead byte
    localparam logic [7:0] DEC_IDLE  = 8'h00;
    localparam logic [7:0] DEC_E2_80 = 8'h01;
    localparam logic [7:0] LEAD_C2   = 8'hC2;
    localparam logic [7:0] LEAD_C3   = 8'hC3;
    localparam logic [7:0] LEAD_E2   = 8'hE2;
    localparam logic [7:0] BYTE_80   = 8'h80;
    localparam logic [7:0] UPPER_BIT = 8'h40;

    // E2 80 xx trail bytes
    localparam logic [7:0] TR_LDQUO = 8'h9C;
    localparam logic [7:0] TR_RDQUO = 8'h9D;
    localparam logic [7:0] TR_HDQUO = 8'h9F;
    localparam logic [7:0] TR_NDASH = 8'h93;
    localparam logic [7:0] TR_MDASH = 8'h94;
    localparam logic [7:0] TR_ELLIP = 8'hA6;

    // folded characters
    localparam logic [7:0] CH_NONE   = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_value;
    } in_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  glyph_x;
        logic [6:0]  glyph_y;
        logic [7:0]  glyph_code;
        logic [31:0] break_offset;
        logic        last;
    } out_t;

    // decoder result: folded character (CH_NONE if none) and next state
    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] dec_next;
    } fold_t;

endpackage

FILE: sv/tpww_ram.sv
// ----------------------------------------------------------------------------
// tpww_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tpww_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/tpww_fold.sv
// ----------------------------------------------------------------------------
// tpww_fold: UTF-8 to Latin-1 folder
// Maps one raw byte and the decoder state to a folded character and next state.
// ----------------------------------------------------------------------------
module tpww_fold (
    input  logic [7:0]     dec_state,
    input  logic [7:0]     byte_value,
    output tpww_pkg::fold_t res
);

    always_comb
    begin
        res.ch       = tpww_pkg::CH_NONE;
        res.dec_next = tpww_pkg::DEC_IDLE;
        unique case (dec_state)
            tpww_pkg::DEC_IDLE:
            begin
                if (byte_value < tpww_pkg::BYTE_80)
                begin
                    res.ch = byte_value;
                end
                else
                begin
                    res.dec_next = byte_value;
                end
            end
            tpww_pkg::LEAD_C2:
            begin
                res.ch = byte_value;
            end
            tpww_pkg::LEAD_C3:
            begin
                res.ch = byte_value | tpww_pkg::UPPER_BIT;
            end
            tpww_pkg::LEAD_E2:
            begin
                if (byte_value == tpww_pkg::BYTE_80)
                begin
                    res.dec_next = tpww_pkg::DEC_E2_80;
                end
            end
            tpww_pkg::DEC_E2_80:
            begin
                if (byte_value == tpww_pkg::TR_LDQUO || byte_value == tpww_pkg::TR_RDQUO ||
                    byte_value == tpww_pkg::TR_HDQUO)
                begin
                    res.ch = tpww_pkg::CH_DQUOTE;
                end
                else if (byte_value == tpww_pkg::TR_NDASH ||
                         byte_value == tpww_pkg::TR_MDASH)
                begin
                    res.ch = tpww_pkg::CH_DASH;
                end
                else if (byte_value == tpww_pkg::TR_ELLIP)
                begin
                    res.ch = tpww_pkg::CH_DOT;
                end
                else
                begin
                    res.ch = tpww_pkg::CH_QUOTE;
                end
            end
            default:
            begin
                // any other lead byte swallows its follower
                res.ch = tpww_pkg::CH_NONE;
            end
        endcase
    end

endmodule

FILE: sv/text_page_word_wrap.sv
// ----------------------------------------------------------------------------
// text_page_word_wrap: greedy word-wrap layout of one page of text
// Folds UTF-8 to Latin-1, buffers words in a RAM, emits placed glyphs and
// page break reports.
// ----------------------------------------------------------------------------
// Timing: the block handles one input transfer at a time. A byte that only
// joins a word (or is swallowed by the decoder), a new-page command and an
// ignored item are taken in S_IDLE alone. A space, LF or CR that ends a word
// goes through accept, fit check, overflow check (a break if the word no
// longer fits the page), the glyph flush (one glyph per cycle out of the
// single word-buffer RAM read port, which sets the glyph rate) and a tail
// step, plus a break step when it ends the page; with no pending word the
// fit check leads to the tail step. End of text goes to the break step. Any
// result waits while the output register is full and out_ready is low.
// Results sit in an output register, so a new input can be taken while the
// last result of the previous one waits. The word buffer RAM is not cleared
// after reset: only entries already written for the current word are ever read.
// ----------------------------------------------------------------------------
module text_page_word_wrap #(
    parameter int unsigned MAX_WORD    = 32,
    parameter int unsigned CHAR_WIDTH  = 6,
    parameter int unsigned LINE_HEIGHT = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  tpww_pkg::in_t                      in_data,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output tpww_pkg::out_t                     out_data,
    // configuration write port
    input  logic                               cfg_wen,
    input  logic [tpww_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_wdata
);

    localparam int unsigned LEN_W = $clog2(MAX_WORD + 1);
    localparam int unsigned IDX_W = $clog2(MAX_WORD);
    localparam int unsigned WW_W  = $clog2(MAX_WORD * CHAR_WIDTH + 1);
    localparam int unsigned GX_W  = $clog2(255 + MAX_WORD * CHAR_WIDTH + 1);
    localparam int unsigned YS_W  = $clog2(128 + LINE_HEIGHT);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIT   = 6'b000010,
        S_WCHK  = 6'b000100,
        S_GLYPH = 6'b001000,
        S_TAIL  = 6'b010000,
        S_BRK   = 6'b100000
    } state_t;

    // configuration registers
    logic [31:0] page_start_reg;
    logic [6:0]  left_reg;
    logic [6:0]  right_reg;
    logic [5:0]  top_reg;
    logic [5:0]  bottom_reg;

    // layout state
    state_t           state_reg,       state_next;
    logic [7:0]       dec_state_reg,   dec_state_next;
    logic [7:0]       cursor_x_reg,    cursor_x_next;
    logic [6:0]       cursor_y_reg,    cursor_y_next;
    logic [31:0]      byte_pos_reg,    byte_pos_next;
    logic [31:0]      word_start_reg,  word_start_next;
    logic [LEN_W-1:0] word_len_reg,    word_len_next;
    logic [WW_W-1:0]  word_width_reg,  word_width_next;
    logic             page_done_reg,   page_done_next;
    logic             is_space_reg,    is_space_next;
    logic             is_lf_reg,       is_lf_next;
    logic [LEN_W-1:0] glyph_idx_reg,   glyph_idx_next;
    logic [GX_W-1:0]  glyph_x_reg,     glyph_x_next;
    logic [31:0]      brk_off_reg,     brk_off_next;
    logic             out_valid_reg,   out_valid_next;
    tpww_pkg::out_t   out_data_reg,    out_data_next;

    // word buffer RAM
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;

    tpww_pkg::fold_t  fold;

    logic             in_xfer;
    logic             out_free;
    logic             is_delim;
    logic [6:0]       nl_y;
    logic [GX_W-1:0]  fit_sum;
    logic [GX_W-1:0]  tail_x_sum;
    logic             space_fit;
    logic             tail_wrap;
    logic [6:0]       y_after;
    logic             tail_brk;
    logic             tail_any;
    logic             last_glyph;

    function automatic logic [7:0] sat8(input logic [GX_W-1:0] v);
        sat8 = (v > GX_W'(255)) ? 8'hFF : v[7:0];
    endfunction

    // true when a line starting at row y would cross the bottom edge
    function automatic logic overflow(input logic [6:0] y, input logic [5:0] bottom);
        overflow = (YS_W'(y) + YS_W'(LINE_HEIGHT)) > YS_W'(bottom);
    endfunction

    tpww_fold u_fold (
        .dec_state  (dec_state_reg),
        .byte_value (in_data.byte_value),
        .res        (fold)
    );

    // Read data is only used once the word is complete (the fit and overflow
    // checks lie between its last write and the first glyph), so no forwarding
    // is needed. The read address is the next glyph index: data for glyph_idx_reg
    // is on ram_rdata in S_GLYPH, and it holds while the index holds during a stall.
    tpww_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WORD)
    ) u_word_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (glyph_idx_next[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign is_delim  = (fold.ch == tpww_pkg::CH_SPACE) || (fold.ch == tpww_pkg::CH_LF) ||
                       (fold.ch == tpww_pkg::CH_CR);
    assign nl_y      = cursor_y_reg + 7'(LINE_HEIGHT);
    assign fit_sum   = GX_W'(cursor_x_reg) + GX_W'(word_width_reg);

    // What follows the word: a space if it still fits, a line feed, and a
    // page break if the resulting line no longer fits on the page. Taken from
    // the cursor after the flush, so it is valid during S_GLYPH and S_TAIL.
    assign tail_x_sum = GX_W'(cursor_x_reg) + GX_W'(CHAR_WIDTH);
    assign space_fit  = is_space_reg && (tail_x_sum <= GX_W'(right_reg));
    assign tail_wrap  = is_lf_reg || (is_space_reg && !space_fit);
    assign y_after    = tail_wrap ? nl_y : cursor_y_reg;
    assign tail_brk   = overflow(y_after, bottom_reg);
    assign tail_any   = space_fit || tail_brk;
    assign last_glyph = (glyph_idx_reg == word_len_reg - LEN_W'(1));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_start_reg <= tpww_pkg::RST_PAGE_START;
            left_reg       <= tpww_pkg::RST_LEFT;
            right_reg      <= tpww_pkg::RST_RIGHT;
            top_reg        <= tpww_pkg::RST_TOP;
            bottom_reg     <= tpww_pkg::RST_BOTTOM;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                tpww_pkg::CFG_PAGE_START: page_start_reg <= cfg_wdata;
                tpww_pkg::CFG_LEFT:       left_reg       <= cfg_wdata[6:0];
                tpww_pkg::CFG_RIGHT:      right_reg      <= cfg_wdata[6:0];
                tpww_pkg::CFG_TOP:        top_reg        <= cfg_wdata[5:0];
                tpww_pkg::CFG_BOTTOM:     bottom_reg     <= cfg_wdata[5:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        dec_state_next  = dec_state_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        byte_pos_next   = byte_pos_reg;
        word_start_next = word_start_reg;
        word_len_next   = word_len_reg;
        word_width_next = word_width_reg;
        page_done_next  = page_done_reg;
        is_space_next   = is_space_reg;
        is_lf_next      = is_lf_reg;
        glyph_idx_next  = glyph_idx_reg;
        glyph_x_next    = glyph_x_reg;
        brk_off_next    = brk_off_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = word_len_reg[IDX_W-1:0];
        ram_wdata       = fold.ch;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_data.opcode == tpww_pkg::OP_NEW_PAGE)
                    begin
                        dec_state_next  = tpww_pkg::DEC_IDLE;
                        cursor_x_next   = {1'b0, left_reg};
                        cursor_y_next   = {1'b0, top_reg};
                        byte_pos_next   = page_start_reg;
                        word_start_next = '0;
                        word_len_next   = '0;
                        word_width_next = '0;
                        page_done_next  = 1'b0;
                    end
                    else if (in_data.opcode == tpww_pkg::OP_EOT && !page_done_reg)
                    begin
                        // pending word is dropped; report the page start
                        brk_off_next = page_start_reg;
                        state_next   = S_BRK;
                    end
                    else if (in_data.opcode == tpww_pkg::OP_TEXT && !page_done_reg)
                    begin
                        dec_state_next = fold.dec_next;
                        byte_pos_next  = byte_pos_reg + 32'd1;
                        if (fold.ch != tpww_pkg::CH_NONE)
                        begin
                            if (is_delim)
                            begin
                                is_space_next = (fold.ch == tpww_pkg::CH_SPACE);
                                is_lf_next    = (fold.ch == tpww_pkg::CH_LF);
                                state_next    = S_FIT;
                            end
                            else
                            begin
                                if (word_len_reg == '0)
                                begin
                                    word_start_next = byte_pos_reg;
                                end
                                // characters past the buffer are dropped
                                if (word_len_reg < LEN_W'(MAX_WORD))
                                begin
                                    ram_we          = 1'b1;
                                    word_len_next   = word_len_reg + LEN_W'(1);
                                    word_width_next = word_width_reg + WW_W'(CHAR_WIDTH);
                                end
                            end
                        end
                    end
                end
            end

            S_FIT:
            begin
                if (word_len_reg == '0)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    if (fit_sum > GX_W'(right_reg))
                    begin
                        cursor_x_next = {1'b0, left_reg};
                        cursor_y_next = nl_y;
                    end
                    state_next = S_WCHK;
                end
            end

            S_WCHK:
            begin
                if (overflow(cursor_y_reg, bottom_reg))
                begin
                    // word does not fit on the page: next page starts at it
                    brk_off_next    = word_start_reg;
                    word_len_next   = '0;
                    word_width_next = '0;
                    state_next      = S_BRK;
                end
                else
                begin
                    glyph_idx_next = '0;
                    glyph_x_next   = GX_W'(cursor_x_reg);
                    cursor_x_next  = sat8(fit_sum);
                    state_next     = S_GLYPH;
                end
            end

            S_GLYPH:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.kind          = tpww_pkg::KIND_GLYPH;
                    out_data_next.glyph_x       = sat8(glyph_x_reg);
                    out_data_next.glyph_y       = cursor_y_reg;
                    out_data_next.glyph_code    = ram_rdata;
                    out_data_next.break_offset  = '0;
                    out_data_next.last          = last_glyph && !tail_any;
                    glyph_x_next                = glyph_x_reg + GX_W'(CHAR_WIDTH);
                    glyph_idx_next              = glyph_idx_reg + LEN_W'(1);
                    if (last_glyph)
                    begin
                        word_len_next   = '0;
                        word_width_next = '0;
                        state_next      = S_TAIL;
                    end
                end
            end

            S_TAIL:
            begin
                brk_off_next = byte_pos_reg;
                if (space_fit)
                begin
                    if (out_free)
                    begin
                        out_valid_next              = 1'b1;
                        out_data_next.kind          = tpww_pkg::KIND_GLYPH;
                        out_data_next.glyph_x       = cursor_x_reg;
                        out_data_next.glyph_y       = cursor_y_reg;
                        out_data_next.glyph_code    = tpww_pkg::CH_SPACE;
                        out_data_next.break_offset  = '0;
                        out_data_next.last          = !tail_brk;
                        cursor_x_next               = sat8(tail_x_sum);
                        state_next                  = tail_brk ? S_BRK : S_IDLE;
                    end
                end
                else
                begin
                    if (tail_wrap)
                    begin
                        cursor_x_next = {1'b0, left_reg};
                        cursor_y_next = nl_y;
                    end
                    state_next = tail_brk ? S_BRK : S_IDLE;
                end
            end

            S_BRK:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.kind          = tpww_pkg::KIND_BREAK;
                    out_data_next.glyph_x       = '0;
                    out_data_next.glyph_y       = '0;
                    out_data_next.glyph_code    = '0;
                    out_data_next.break_offset  = brk_off_reg;
                    out_data_next.last          = 1'b1;
                    page_done_next              = 1'b1;
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dec_state_reg  <= tpww_pkg::DEC_IDLE;
            cursor_x_reg   <= {1'b0, tpww_pkg::RST_LEFT};
            cursor_y_reg   <= {1'b0, tpww_pkg::RST_TOP};
            byte_pos_reg   <= tpww_pkg::RST_PAGE_START;
            word_start_reg <= '0;
            word_len_reg   <= '0;
            word_width_reg <= '0;
            page_done_reg  <= 1'b0;
            glyph_idx_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            dec_state_reg  <= dec_state_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            byte_pos_reg   <= byte_pos_next;
            word_start_reg <= word_start_next;
            word_len_reg   <= word_len_next;
            word_width_reg <= word_width_next;
            page_done_reg  <= page_done_next;
            glyph_idx_reg  <= glyph_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        is_space_reg <= is_space_next;
        is_lf_reg    <= is_lf_next;
        glyph_x_reg  <= glyph_x_next;
        brk_off_reg  <= brk_off_next;
        out_data_reg <= out_data_next;
    end

    // a finished page leaves the sequencer idle until the next command
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        page_done_reg |-> state_reg == S_IDLE)
        else $error("page done while layout still busy");

    // a break report always closes the results of its input
    a_break_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.kind == tpww_pkg::KIND_BREAK) |-> out_data.last)
        else $error("break report without last");

    // the flush never reads past the buffered word
    a_glyph_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GLYPH |-> glyph_idx_reg < word_len_reg)
        else $error("glyph index beyond word length");

    // the buffer is written only while collecting a word on an open page
    a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE && !page_done_reg && word_len_reg < LEN_W'(MAX_WORD)))
        else $error("word buffer written outside collection");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the page word-wrap engine
// Streams text bytes and commands through the input channel, predicts every
// glyph placement and page break in a behavioral layout predictor, and checks
// each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    // block geometry, passed to the instance
    localparam int WORD_CAP = 32;
    localparam int GLYPH_W  = 6;
    localparam int ROW_H    = 8;

    // codes the package leaves out
    localparam logic [1:0]                     OP_SPARE  = 2'd3;
    localparam logic [tpww_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    // run control
    localparam int SETTLE      = 48;        // longest word flush plus margin
    localparam int DRAIN_LIMIT = 20000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT     = 300;       // accepted transfers before the long stall
    localparam int HOLD_LEN    = 400;
    localparam int PRINT_CAP   = 100;

    localparam logic [7:0] E2_TRAILS [6] =
        '{tpww_pkg::TR_LDQUO, tpww_pkg::TR_RDQUO, tpww_pkg::TR_HDQUO,
          tpww_pkg::TR_NDASH, tpww_pkg::TR_MDASH, tpww_pkg::TR_ELLIP};

    localparam tpww_pkg::out_t NO_RESULT = '0;
    // EOT on the first page after reset reports the reset page start
    localparam tpww_pkg::out_t EOT_AT_RESET  = '{tpww_pkg::KIND_BREAK, 8'd0, 7'd0,
        tpww_pkg::CH_NONE, tpww_pkg::RST_PAGE_START, 1'b1};
    // space on the second line with reset margins: x = left, y = top + row height
    localparam tpww_pkg::out_t SPACE_LINE_2  = '{tpww_pkg::KIND_GLYPH, 8'd2, 7'd10,
        tpww_pkg::CH_SPACE, 32'd0, 1'b1};

    typedef struct {
        tpww_pkg::in_t  item;
        bit             typed;    // want holds the single expected result
        tpww_pkg::out_t want;
    } row_t;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_e;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    tpww_pkg::in_t  in_data;
    logic out_valid;
    logic out_ready;
    tpww_pkg::out_t out_data;
    logic                           cfg_wen;
    logic [tpww_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                    cfg_wdata;

    text_page_word_wrap #(
        .MAX_WORD    (WORD_CAP),
        .CHAR_WIDTH  (GLYPH_W),
        .LINE_HEIGHT (ROW_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Layout predictor state: register shadows and page/word state
    // ------------------------------------------------------------------------
    logic [31:0] sh_page;
    logic [6:0]  sh_left;
    logic [6:0]  sh_right;
    logic [5:0]  sh_top;
    logic [5:0]  sh_bottom;

    logic [7:0]  dec_state;     // idle, after E2 80, or the pending lead byte
    int          cur_x;
    int          cur_y;
    logic [31:0] byte_pos;
    logic [31:0] word_start;
    int          word_len;
    logic [7:0]  word_buf [WORD_CAP];
    bit          pg_done;

    tpww_pkg::out_t step_placements [$];  // results of the transfer being predicted
    tpww_pkg::out_t placement_q [$];      // predicted results not yet seen on the output
    tpww_pkg::in_t  text_q [$];           // generated byte stream waiting to be sent

    int  mismatch_count = 0;
    int  accepted_items = 0;
    int  burst_left     = 0;
    bit  idle_enable    = 1'b1;
    int  cycle_count    = 0;

    function automatic tpww_pkg::in_t make_item(input logic [1:0] op, input logic [7:0] b);
        tpww_pkg::in_t it;
        it.opcode     = op;
        it.byte_value = b;
        return it;
    endfunction

    function automatic int clamp_x(input int v);
        return (v > 255) ? 255 : v;
    endfunction

    function automatic bit page_overflow();
        return cur_y > int'(sh_bottom) - ROW_H;
    endfunction

    task automatic next_line();
        cur_x = int'(sh_left);
        cur_y = (cur_y + ROW_H) & 'h7F;
    endtask

    task automatic start_page_model();
        dec_state  = tpww_pkg::DEC_IDLE;
        cur_x      = int'(sh_left);
        cur_y      = int'(sh_top);
        byte_pos   = sh_page;
        word_start = '0;
        word_len   = 0;
        pg_done    = 1'b0;
    endtask

    task automatic add_placement(input logic kind, input int x, input int y,
                                 input logic [7:0] code, input logic [31:0] off);
        tpww_pkg::out_t p;
        p.kind         = kind;
        p.glyph_x      = x[7:0];
        p.glyph_y      = y[6:0];
        p.glyph_code   = code;
        p.break_offset = off;
        p.last         = 1'b0;
        step_placements.push_back(p);
    endtask

    // Works out the results of one accepted input transfer.
    task automatic predict_layout(input tpww_pkg::in_t item);
        logic [7:0]     b;
        logic [7:0]     ch;
        logic [7:0]     prev;
        logic [31:0]    pos;
        int             ww;
        bit             broke;
        tpww_pkg::out_t tail;
        step_placements.delete();
        b = item.byte_value;
        if (item.opcode == tpww_pkg::OP_NEW_PAGE)
        begin
            start_page_model();
        end
        else if (item.opcode == OP_SPARE || pg_done)
        begin
            // nothing happens
        end
        else if (item.opcode == tpww_pkg::OP_EOT)
        begin
            // pending word is dropped
            add_placement(tpww_pkg::KIND_BREAK, 0, 0, tpww_pkg::CH_NONE, sh_page);
            pg_done = 1'b1;
        end
        else
        begin
            // UTF-8 fold
            ch = tpww_pkg::CH_NONE;
            if (dec_state == tpww_pkg::DEC_IDLE)
            begin
                if (b < tpww_pkg::BYTE_80)
                    ch = b;
                else
                    dec_state = b;
            end
            else
            begin
                prev      = dec_state;
                dec_state = tpww_pkg::DEC_IDLE;
                case (prev)
                    tpww_pkg::LEAD_C2: ch = b;
                    tpww_pkg::LEAD_C3: ch = b | tpww_pkg::UPPER_BIT;
                    tpww_pkg::LEAD_E2:
                    begin
                        if (b == tpww_pkg::BYTE_80)
                            dec_state = tpww_pkg::DEC_E2_80;
                    end
                    tpww_pkg::DEC_E2_80:
                    begin
                        if (b == tpww_pkg::TR_LDQUO || b == tpww_pkg::TR_RDQUO ||
                            b == tpww_pkg::TR_HDQUO)
                            ch = tpww_pkg::CH_DQUOTE;
                        else if (b == tpww_pkg::TR_NDASH || b == tpww_pkg::TR_MDASH)
                            ch = tpww_pkg::CH_DASH;
                        else if (b == tpww_pkg::TR_ELLIP)
                            ch = tpww_pkg::CH_DOT;
                        else
                            ch = tpww_pkg::CH_QUOTE;
                    end
                    default: ;  // unknown lead swallows its trail byte
                endcase
            end

            pos      = byte_pos;
            byte_pos = pos + 32'd1;     // wraps mod 2^32

            if (ch == tpww_pkg::CH_NONE)
            begin
                // swallowed
            end
            else if (ch != tpww_pkg::CH_SPACE && ch != tpww_pkg::CH_LF &&
                     ch != tpww_pkg::CH_CR)
            begin
                if (word_len == 0)
                    word_start = pos;
                // overlong words lose their tail
                if (word_len < WORD_CAP)
                begin
                    word_buf[word_len] = ch;
                    word_len++;
                end
            end
            else
            begin
                broke = 1'b0;
                if (word_len > 0)
                begin
                    ww = word_len * GLYPH_W;
                    if (cur_x + ww > int'(sh_right))
                        next_line();
                    if (page_overflow())
                    begin
                        // word does not fit on the page: next page starts with it
                        add_placement(tpww_pkg::KIND_BREAK, 0, 0, tpww_pkg::CH_NONE,
                                      word_start);
                        pg_done  = 1'b1;
                        word_len = 0;
                        broke    = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < word_len; i++)
                            add_placement(tpww_pkg::KIND_GLYPH, clamp_x(cur_x + i * GLYPH_W),
                                          cur_y, word_buf[i], '0);
                        cur_x    = clamp_x(cur_x + ww);
                        word_len = 0;
                    end
                end
                if (!broke)
                begin
                    if (ch == tpww_pkg::CH_SPACE)
                    begin
                        if (cur_x + GLYPH_W <= int'(sh_right))
                        begin
                            add_placement(tpww_pkg::KIND_GLYPH, cur_x, cur_y,
                                          tpww_pkg::CH_SPACE, '0);
                            cur_x = clamp_x(cur_x + GLYPH_W);
                        end
                        else
                            next_line();
                    end
                    else if (ch == tpww_pkg::CH_LF)
                        next_line();
                    if (page_overflow())
                    begin
                        add_placement(tpww_pkg::KIND_BREAK, 0, 0, tpww_pkg::CH_NONE,
                                      byte_pos);
                        pg_done = 1'b1;
                    end
                end
            end
        end
        if (step_placements.size() != 0)
        begin
            tail      = step_placements.pop_back();
            tail.last = 1'b1;
            step_placements.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic flag_error(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Every output transfer is matched against the oldest prediction.
    always @(posedge clk)
    begin
        tpww_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (placement_q.size() == 0)
                flag_error($sformatf("result with nothing expected: %h", out_data));
            else
            begin
                want = placement_q.pop_front();
                compare_field("kind", 32'(out_data.kind), 32'(want.kind));
                compare_field("glyph_x", 32'(out_data.glyph_x), 32'(want.glyph_x));
                compare_field("glyph_y", 32'(out_data.glyph_y), 32'(want.glyph_y));
                compare_field("glyph_code", 32'(out_data.glyph_code),
                              32'(want.glyph_code));
                compare_field("break_offset", out_data.break_offset, want.break_offset);
                compare_field("last", 32'(out_data.last), 32'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: its own stall pattern, switched among four modes at random,
    // plus one long hold-off once traffic is well under way so the block
    // backs up and stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin
        rx_mode_e mode;
        int       mode_left;
        int       hold_left;
        bit       held;
        int       tick;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        held      = 1'b0;
        tick      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (!held && accepted_items >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_e'($urandom_range(0, 3));
                mode_left = int'($urandom_range(64, 400));
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_FREE:     out_ready <= 1'b1;
                    RX_RANDOM:   out_ready <= ($urandom_range(0, 9) < 7);
                    RX_PERIODIC: out_ready <= ((tick % 5) < 2);
                    default:     out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Hard stop if the block hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Bursts of random length separated by random gaps; gaps off leaves
    // valid high across items.
    task automatic pace_sender();
        int gap;
        if (idle_enable)
        begin
            if (burst_left == 0)
            begin
                gap = int'($urandom_range(1, 12));
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = int'($urandom_range(1, 24));
            end
            burst_left--;
        end
    endtask

    // One input transfer; the prediction is made at the accepting edge.
    task automatic send_item(input tpww_pkg::in_t item, input bit typed,
                             input tpww_pkg::out_t want);
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        accepted_items++;
        predict_layout(item);
        if (typed)
            placement_q.push_back(want);
        else
            foreach (step_placements[i])
                placement_q.push_back(step_placements[i]);
    endtask

    task automatic push_text(input logic [7:0] b);
        text_q.push_back(make_item(tpww_pkg::OP_TEXT, b));
    endtask

    // Appends one token: mostly a word plus separator, sometimes a command
    // or a stray byte.
    task automatic queue_token();
        int         pick;
        int         len;
        int         sel;
        logic [7:0] trail;
        pick = int'($urandom_range(0, 99));
        if (pick < 3)
            text_q.push_back(make_item(tpww_pkg::OP_EOT, 8'($urandom)));
        else if (pick < 5)
            text_q.push_back(make_item(tpww_pkg::OP_NEW_PAGE, 8'($urandom)));
        else if (pick < 7)
            text_q.push_back(make_item(OP_SPARE, 8'($urandom)));
        else if (pick < 17)
            push_text(8'($urandom));
        else
        begin
            // some words run past the word buffer
            len = ($urandom_range(0, 11) == 0) ? int'($urandom_range(28, 40))
                                               : int'($urandom_range(1, 9));
            for (int k = 0; k < len; k++)
            begin
                sel = int'($urandom_range(0, 19));
                if (sel < 15)
                    push_text(8'($urandom_range(8'h21, 8'h7E)));
                else if (sel == 15)
                begin
                    push_text(tpww_pkg::LEAD_C2);
                    push_text(8'($urandom));
                end
                else if (sel == 16)
                begin
                    push_text(tpww_pkg::LEAD_C3);
                    push_text(8'($urandom));
                end
                else if (sel == 17)
                begin
                    trail = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                         : E2_TRAILS[$urandom_range(0, 5)];
                    push_text(tpww_pkg::LEAD_E2);
                    push_text(tpww_pkg::BYTE_80);
                    push_text(trail);
                end
                else if (sel == 18)
                begin
                    push_text(tpww_pkg::LEAD_E2);
                    push_text(8'($urandom));
                end
                else
                begin
                    push_text(8'($urandom_range(8'h80, 8'hFF)));
                    push_text(8'($urandom));
                end
            end
            sel = int'($urandom_range(0, 99));
            if (sel < 75)
                push_text(tpww_pkg::CH_SPACE);
            else if (sel < 87)
                push_text(tpww_pkg::CH_LF);
            else if (sel < 95)
                push_text(tpww_pkg::CH_CR);
            else
            begin
                push_text(tpww_pkg::CH_SPACE);
                push_text(tpww_pkg::CH_SPACE);
            end
        end
    endtask

    // Random text; after a page break mostly opens the next page, now and
    // then sends something the finished page has to ignore.
    task automatic run_text(input int count, input bit gaps_on);
        int            sent;
        bit            ignored;
        tpww_pkg::in_t item;
        idle_enable = gaps_on;
        sent = 0;
        while (sent < count)
        begin
            if (pg_done && $urandom_range(0, 7) != 0)
                item = make_item(tpww_pkg::OP_NEW_PAGE, 8'($urandom));
            else
            begin
                if (text_q.size() == 0)
                    queue_token();
                item = text_q.pop_front();
            end
            ignored = (item.opcode == OP_SPARE) ||
                      (pg_done && item.opcode != tpww_pkg::OP_NEW_PAGE);
            pace_sender();
            send_item(item, 1'b0, NO_RESULT);
            if (!ignored)
                sent++;
        end
    endtask

    task automatic open_page();
        pace_sender();
        send_item(make_item(tpww_pkg::OP_NEW_PAGE, 8'($urandom)), 1'b0, NO_RESULT);
    endtask

    // Stop sending, let every predicted result arrive, then give a word
    // flush with no result time to finish.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (placement_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tpww_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            tpww_pkg::CFG_PAGE_START: sh_page   = val;
            tpww_pkg::CFG_LEFT:       sh_left   = val[6:0];
            tpww_pkg::CFG_RIGHT:      sh_right  = val[6:0];
            tpww_pkg::CFG_TOP:        sh_top    = val[5:0];
            tpww_pkg::CFG_BOTTOM:     sh_bottom = val[5:0];
            default: ;
        endcase
    endtask

    // Rewrites all margins while idle; bits above each field are junk.
    task automatic set_layout(input logic [31:0] page, input logic [6:0] left,
                              input logic [6:0] right, input logic [5:0] top,
                              input logic [5:0] bottom);
        drain_and_settle();
        write_reg(tpww_pkg::CFG_PAGE_START, page);
        write_reg(tpww_pkg::CFG_LEFT,   {25'($urandom), left});
        write_reg(tpww_pkg::CFG_RIGHT,  {25'($urandom), right});
        write_reg(tpww_pkg::CFG_TOP,    {26'($urandom), top});
        write_reg(tpww_pkg::CFG_BOTTOM, {26'($urandom), bottom});
        write_reg(CFG_SPARE,  $urandom);
        cfg_wen <= 1'b0;
    endtask

    // Directed rows, run with reset margins: fold cases, swallowed leads,
    // byte extremes, every opcode and the finished-page rule.
    row_t directed_rows [25] = '{
        '{'{tpww_pkg::OP_TEXT, tpww_pkg::LEAD_C3},   1'b0, NO_RESULT},  // C3 A9 -> e acute
        '{'{tpww_pkg::OP_TEXT, 8'hA9},               1'b0, NO_RESULT},
        '{'{tpww_pkg::OP_TEXT, tpww_pkg::LEAD_E2},   1'b0, NO_RESULT},  // left double quote
        '{'{tpww_pkg::OP_TEXT, tpww_pkg::BYTE_80},   1'b0, NO_RESULT},
        '{'{tpww_pkg::OP_TEXT, tpww_pkg::TR_LDQUO},  1'b0, NO_RESULT},
        '{'{tpww_pkg::OP_TEXT, tpww_pkg::LEAD_E2},   1'b0, NO_RESULT},  // ellipsis -> dot
        '{'{tpww_pkg::OP_TEXT, tpww_pkg::BYTE_80},   1'b0, NO_RESULT},
        '{'{tpww_pkg::OP_TEXT, tpww_pkg::TR_ELLIP},  1'b0, NO_RESULT},
        '{'{tpww_pkg::OP_TEXT, tpww_pkg::LEAD_C2},   1'b0, NO_RESULT},  // C2 FF -> FF
        '{'{tpww_pkg::OP_TEXT, 8'hFF},               1'b0, NO_RESULT},
        '{'{tpww_pkg::OP_TEXT, 8'hE5},               1'b0, NO_RESULT},  // unknown lead eats 'A'
        '{'{tpww_pkg::OP_TEXT, 8'h41},               1'b0, NO_RESULT},
        '{'{tpww_pkg::OP_TEXT, tpww_pkg::CH_CR},     1'b0, NO_RESULT},  // CR flushes the word
        '{'{tpww_pkg::OP_TEXT, 8'h00},               1'b0, NO_RESULT},  // NUL folds to nothing
        '{'{tpww_pkg::OP_TEXT, 8'h7F},               1'b0, NO_RESULT},
        '{'{tpww_pkg::OP_TEXT, tpww_pkg::CH_LF},     1'b0, NO_RESULT},  // flush, then new line
        '{'{tpww_pkg::OP_TEXT, tpww_pkg::LEAD_E2},   1'b0, NO_RESULT},  // E2 not followed by 80
        '{'{tpww_pkg::OP_TEXT, 8'h81},               1'b0, NO_RESULT},
        '{'{tpww_pkg::OP_TEXT, tpww_pkg::TR_NDASH},  1'b0, NO_RESULT},  // stray trail as lead
        '{'{tpww_pkg::OP_TEXT, tpww_pkg::CH_SPACE},  1'b0, NO_RESULT},  // ... eats this space
        '{'{tpww_pkg::OP_TEXT, tpww_pkg::CH_SPACE},  1'b1, SPACE_LINE_2},
        '{'{tpww_pkg::OP_EOT, 8'hFF},                1'b1, EOT_AT_RESET},
        '{'{tpww_pkg::OP_TEXT, 8'h61},               1'b0, NO_RESULT},  // page done: ignored
        '{'{OP_SPARE, 8'hFF},                        1'b0, NO_RESULT},
        '{'{tpww_pkg::OP_NEW_PAGE, 8'h00},           1'b0, NO_RESULT}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int waited;
        sh_page   = tpww_pkg::RST_PAGE_START;
        sh_left   = tpww_pkg::RST_LEFT;
        sh_right  = tpww_pkg::RST_RIGHT;
        sh_top    = tpww_pkg::RST_TOP;
        sh_bottom = tpww_pkg::RST_BOTTOM;
        start_page_model();
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_wen   = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            pace_sender();
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        end

        // full-width page, sender pauses for a full drain halfway
        set_layout(32'h0000_1000, 7'd0, 7'd127, 6'd0, 6'd63);
        open_page();
        run_text(40, 1'b1);
        drain_and_settle();
        run_text(40, 1'b0);

        // margins reversed: nothing fits, every page ends at its first delimiter
        set_layout(32'h1234_5678, 7'd127, 7'd0, 6'd63, 6'd0);
        open_page();
        run_text(30, 1'b1);

        // left past right: one word per line, x saturates, offset wraps
        set_layout(32'hFFFF_FFFE, 7'd120, 7'd10, 6'd0, 6'd63);
        open_page();
        run_text(70, 1'b1);

        // ordinary page; the long receiver hold-off lands around here
        set_layout($urandom, 7'd5, 7'd100, 6'd10, 6'd40);
        open_page();
        run_text(110, 1'($urandom_range(0, 1)));

        repeat (3)
        begin
            set_layout($urandom, 7'($urandom_range(0, 24)), 7'($urandom_range(60, 127)),
                       6'($urandom_range(0, 12)), 6'($urandom_range(24, 63)));
            open_page();
            run_text(50, 1'($urandom_range(0, 1)));
        end

        in_valid <= 1'b0;
        waited = 0;
        while (placement_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
        if (placement_q.size() != 0)
            flag_error($sformatf("%0d expected results never arrived", placement_q.size()));

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
